// File: rtl/lpmr_pkg.sv
// Package for the length-prefixed message ring: sizes, request codes, status codes, FSM states, memory request.
// No dependencies.
package lpmr_pkg;
  localparam int NUM_CHANNELS = 4;
  localparam int QUEUE_BYTES = 1024;
  localparam int MAX_MSG_BYTES = 256;
  localparam int NQ = 2 * NUM_CHANNELS;
  localparam int QW = $clog2(NQ);
  localparam int OW = $clog2(QUEUE_BYTES);
  localparam int AW = QW + OW;
  localparam int CW = 9;

  typedef enum logic [1:0] {
    FN_SEND_START = 2'd0,
    FN_SEND_BYTE  = 2'd1,
    FN_RECV_START = 2'd2,
    FN_RECV_BYTE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_IDLE  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HWR,
    S_HRD,
    S_BRD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } mem_req_t;
endpackage

// File: rtl/length_prefixed_message_ring.sv
// Top level of the length-prefixed message ring: request decode, pointer tables, header sequencer.
// Depends on lpmr_pkg and lpmr_ram.
//
// Requests arrive on in_* and each gives exactly one response on out_*.
// A send start writes the 4-byte header and then responds.
// A receive start responds once its 4-byte header has been read; its first
// header read is issued in the accepting cycle to cover the memory latency.
// A send byte is written in the accepting cycle; a receive byte also passes S_BRD.
// The byte memory has one write and one read port, which sets this sequencing.
// Rejected requests and bytes without an open transfer respond straight from S_IDLE.
// One request is worked on at a time; in_tready is low until the response
// register is free again, so a stalled receiver holds the block.
// Reset empties all rings and closes both transfers; ring bytes are not cleared.
module length_prefixed_message_ring import lpmr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,  // func[1:0], channel[3:2], direction[4], length[13:5], data_in[21:14]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // status[1:0], length_out[10:2], data_out[18:11]
  output logic        out_tlast
);
  state_t state_r, state_nxt;
  logic [OW-1:0] head_r [NQ];
  logic [OW-1:0] tail_r [NQ];
  logic [CW-1:0] cnt_r [NQ];
  logic s_act_r, r_act_r;
  logic [QW-1:0] s_q_r, r_q_r, q_r;
  logic [8:0] s_rem_r, r_rem_r, len_r;
  logic [OW-1:0] s_cur_r, r_cur_r, cur_r;
  logic [2:0] step_r;
  logic [1:0] st_r;
  logic [8:0] lo_r;
  logic [7:0] do_r;
  logic last_r, ov_r;
  mem_req_t mreq;
  logic [7:0] rdata;

  logic [1:0] f;
  logic [1:0] ch;
  logic [QW-1:0] q;
  logic [8:0] ilen;
  logic [7:0] din;
  logic [OW:0] room;
  logic [OW-1:0] t, h;
  logic acc;

  assign f = in_tdata[1:0];
  assign ch = in_tdata[3:2];
  assign q = QW'({ch, in_tdata[4]});
  assign ilen = in_tdata[13:5];
  assign din = in_tdata[21:14];
  assign acc = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE) && !ov_r;
  assign t = tail_r[q];
  assign h = head_r[q];

  always_comb begin
    if (t == h) room = (OW+1)'(QUEUE_BYTES);
    else if (t > h) room = (OW+1)'(QUEUE_BYTES) - {1'b0, t - h};
    else room = {1'b0, h - t - 1'b1};
  end

  lpmr_ram u_ram (.clk(clk), .req(mreq), .rdata(rdata));

  always_comb begin
    state_nxt = state_r;
    mreq = '0;
    case (state_r)
      S_IDLE: if (acc) begin
        if (f == FN_SEND_START && (32'(ch) < NUM_CHANNELS) && ilen <= 9'(MAX_MSG_BYTES)
            && 32'(room) > 32'(ilen) + 4) state_nxt = S_HWR;
        else if (f == FN_RECV_START && (32'(ch) < NUM_CHANNELS) && cnt_r[q] != '0) begin
          state_nxt = S_HRD;
          mreq.re = 1'b1;
          mreq.raddr = {q, h};
        end else if (f == FN_SEND_BYTE && s_act_r) begin
          mreq.we = 1'b1;
          mreq.waddr = {s_q_r, s_cur_r};
          mreq.wdata = din;
        end else if (f == FN_RECV_BYTE && r_act_r) begin
          state_nxt = S_BRD;
          mreq.re = 1'b1;
          mreq.raddr = {r_q_r, r_cur_r};
        end
      end
      S_HWR: begin
        mreq.we = 1'b1;
        mreq.waddr = {q_r, cur_r};
        mreq.wdata = (step_r == 3'd0) ? len_r[7:0] : (step_r == 3'd1) ? {7'd0, len_r[8]} : 8'd0;
        if (step_r == 3'd3) state_nxt = S_IDLE;
      end
      S_HRD: begin
        mreq.re = step_r < 3'd3;
        mreq.raddr = {q_r, cur_r};
        if (step_r == 3'd3) state_nxt = S_IDLE;
      end
      S_BRD: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      s_act_r <= 1'b0;
      r_act_r <= 1'b0;
      ov_r <= 1'b0;
      step_r <= '0;
      for (int i = 0; i < NQ; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (ov_r && out_tready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: if (acc) begin
          st_r <= ST_OK;
          lo_r <= '0;
          do_r <= '0;
          last_r <= 1'b0;
          step_r <= '0;
          ov_r <= 1'b1;
          case (f)
            FN_SEND_START: begin
              s_act_r <= 1'b0;
              if (state_nxt == S_HWR) begin
                ov_r <= 1'b0;
                q_r <= q;
                cur_r <= t;
                len_r <= ilen;
              end else st_r <= ST_FULL;
            end
            FN_SEND_BYTE: begin
              if (!s_act_r) st_r <= ST_IDLE;
              else begin
                s_cur_r <= s_cur_r + 1'b1;
                s_rem_r <= s_rem_r - 1'b1;
                if (s_rem_r == 9'd1) begin
                  tail_r[s_q_r] <= s_cur_r + 1'b1;
                  cnt_r[s_q_r] <= cnt_r[s_q_r] + 1'b1;
                  s_act_r <= 1'b0;
                  last_r <= 1'b1;
                end
              end
            end
            FN_RECV_START: begin
              r_act_r <= 1'b0;
              if (state_nxt == S_HRD) begin
                ov_r <= 1'b0;
                q_r <= q;
                cur_r <= h + 1'b1;
              end else st_r <= ST_EMPTY;
            end
            default: begin
              if (!r_act_r) st_r <= ST_IDLE;
              else ov_r <= 1'b0;
            end
          endcase
        end
        S_HWR: begin
          cur_r <= cur_r + 1'b1;
          step_r <= step_r + 1'b1;
          if (step_r == 3'd3) begin
            ov_r <= 1'b1;
            if (len_r == '0) begin
              tail_r[q_r] <= cur_r + 1'b1;
              cnt_r[q_r] <= cnt_r[q_r] + 1'b1;
            end else begin
              s_act_r <= 1'b1;
              s_q_r <= q_r;
              s_rem_r <= len_r;
              s_cur_r <= cur_r + 1'b1;
            end
          end
        end
        S_HRD: begin
          step_r <= step_r + 1'b1;
          if (step_r < 3'd3) cur_r <= cur_r + 1'b1;
          if (step_r == 3'd0) lo_r <= {1'b0, rdata};
          if (step_r == 3'd1) lo_r[8] <= rdata[0];
          if (step_r == 3'd3) begin
            ov_r <= 1'b1;
            if (lo_r == '0) begin
              head_r[q_r] <= cur_r;
              cnt_r[q_r] <= cnt_r[q_r] - 1'b1;
            end else begin
              r_act_r <= 1'b1;
              r_q_r <= q_r;
              r_rem_r <= lo_r;
              r_cur_r <= cur_r;
            end
          end
        end
        S_BRD: begin
          ov_r <= 1'b1;
          do_r <= rdata;
          r_cur_r <= r_cur_r + 1'b1;
          r_rem_r <= r_rem_r - 1'b1;
          if (r_rem_r == 9'd1) begin
            head_r[r_q_r] <= r_cur_r + 1'b1;
            if (cnt_r[r_q_r] != '0) cnt_r[r_q_r] <= cnt_r[r_q_r] - 1'b1;
            r_act_r <= 1'b0;
            last_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {5'd0, do_r, lo_r, st_r};
  assign out_tlast = last_r;

  a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_tvalid) else $error("response during sequence");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("response dropped");
  a_hwr_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HWR) |-> (step_r <= 3'd3)) else $error("header step overrun");
endmodule

// File: rtl/lpmr_ram.sv
// Byte memory holding all rings: one write port, one read port, registered read data.
// Depends on lpmr_pkg.
module lpmr_ram import lpmr_pkg::*; (
  input  logic       clk,
  input  mem_req_t   req,
  output logic [7:0] rdata
);
  logic [7:0] mem [NQ*QUEUE_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end
endmodule

// File: sim/length_prefixed_message_ring_tb.sv
// Testbench for the length-prefixed message ring: drives requests, predicts each response.
// Depends on lpmr_pkg and the length_prefixed_message_ring RTL.
module length_prefixed_message_ring_tb;
  import lpmr_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [8:0] len_out;
    logic [7:0] dout;
    logic       last;
  } resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;

  length_prefixed_message_ring dut (.*);

  always #5 clk = ~clk;

  logic [7:0]  ring_mem [NQ][QUEUE_BYTES];
  logic [9:0]  head_ptr [NQ];
  logic [9:0]  tail_ptr [NQ];
  int          msg_cnt [NQ];
  bit          tx_open, rx_open;
  int          tx_q, tx_left, rx_q, rx_left;
  logic [9:0]  tx_cur, rx_cur;

  resp_t       expected_resps[$];
  int          errors = 0;
  int          cycles = 0;
  int          n_resp = 0;
  bit          quiet = 1'b0;

  function automatic resp_t predict_resp(logic [1:0] fn, logic [1:0] ch, logic dir,
                                         logic [8:0] len, logic [7:0] din);
    resp_t r;
    int q, t, h, room, m;
    logic [9:0] c;
    r = '0;
    q = ch * 2 + dir;
    case (func_t'(fn))
      FN_SEND_START: begin
        tx_open = 0;
        t = tail_ptr[q];
        h = head_ptr[q];
        room = (t == h) ? QUEUE_BYTES : (t > h) ? QUEUE_BYTES - (t - h) : h - t - 1;
        if (ch >= NUM_CHANNELS || len > MAX_MSG_BYTES || room <= len + 4) begin
          r.status = ST_FULL;
        end else begin
          c = tail_ptr[q];
          for (int i = 0; i < 4; i++) begin
            ring_mem[q][c] = 8'((32'(len) >> (8 * i)) & 32'hff);
            c++;
          end
          if (len == 0) begin
            tail_ptr[q] = c;
            msg_cnt[q]++;
          end else begin
            tx_open = 1;
            tx_q = q;
            tx_left = len;
            tx_cur = c;
          end
        end
      end
      FN_SEND_BYTE: begin
        if (!tx_open) begin
          r.status = ST_IDLE;
        end else begin
          ring_mem[tx_q][tx_cur] = din;
          tx_cur++;
          tx_left--;
          if (tx_left == 0) begin
            tail_ptr[tx_q] = tx_cur;
            msg_cnt[tx_q]++;
            tx_open = 0;
            r.last = 1;
          end
        end
      end
      FN_RECV_START: begin
        rx_open = 0;
        if (ch >= NUM_CHANNELS || msg_cnt[q] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          c = head_ptr[q];
          m = 0;
          for (int i = 0; i < 4; i++) begin
            m |= int'(ring_mem[q][c]) << (8 * i);
            c++;
          end
          r.len_out = 9'(m);
          if (m == 0) begin
            head_ptr[q] = c;
            msg_cnt[q]--;
          end else begin
            rx_open = 1;
            rx_q = q;
            rx_left = m;
            rx_cur = c;
          end
        end
      end
      default: begin
        if (!rx_open) begin
          r.status = ST_IDLE;
        end else begin
          r.dout = ring_mem[rx_q][rx_cur];
          rx_cur++;
          rx_left--;
          if (rx_left == 0) begin
            head_ptr[rx_q] = rx_cur;
            if (msg_cnt[rx_q] > 0) msg_cnt[rx_q]--;
            rx_open = 0;
            r.last = 1;
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_request(func_t fn, logic [1:0] ch, logic dir, logic [8:0] len,
                              logic [7:0] din);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b0, din, len, dir, ch, fn};
    expected_resps.insert(expected_resps.size(), predict_resp(fn, ch, dir, len, din));
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic idle_input;
    in_tvalid <= 1'b0;
  endtask

  // Receiver: stalls in random bursts, compares each response with the oldest prediction.
  initial begin
    int stall;
    resp_t got, want;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 11);
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = {out_tdata[1:0], out_tdata[10:2], out_tdata[18:11], out_tlast};
        n_resp++;
        if (expected_resps.size() == 0) begin
          $error("response with no request pending");
          errors++;
        end else begin
          want = expected_resps.pop_front();
          if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            errors++;
          end
          if (got.len_out !== want.len_out) begin
            $error("length_out expected %0d actual %0d", want.len_out, got.len_out);
            errors++;
          end
          if (got.dout !== want.dout) begin
            $error("data_out expected %0d actual %0d", want.dout, got.dout);
            errors++;
          end
          if (got.last !== want.last) begin
            $error("last expected %0d actual %0d", want.last, got.last);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_message(logic [1:0] ch, logic dir, int len);
    send_request(FN_SEND_START, ch, dir, 9'(len), 8'($urandom));
    for (int i = 0; i < len; i++) send_request(FN_SEND_BYTE, 2'($urandom), 1'($urandom),
                                               9'($urandom), 8'($urandom));
  endtask

  task automatic read_message(logic [1:0] ch, logic dir, int len);
    send_request(FN_RECV_START, ch, dir, 9'($urandom), 8'($urandom));
    for (int i = 0; i < len; i++) send_request(FN_RECV_BYTE, 2'($urandom), 1'($urandom),
                                               9'($urandom), 8'($urandom));
  endtask

  task automatic test_idle_cases;
    send_request(FN_SEND_BYTE, 2'd3, 1'b1, 9'h1ff, 8'hff);
    send_request(FN_RECV_BYTE, 2'd0, 1'b0, 9'h000, 8'h00);
    send_request(FN_RECV_START, 2'd2, 1'b1, 9'h000, 8'h00);
    send_request(FN_SEND_START, 2'd1, 1'b0, 9'd257, 8'h00);
    send_request(FN_SEND_START, 2'd1, 1'b0, 9'h1ff, 8'h00);
  endtask

  task automatic test_edge_lengths;
    send_message(2'd0, 1'b0, 0);
    send_request(FN_RECV_START, 2'd0, 1'b0, 9'h0, 8'h0);
    send_message(2'd3, 1'b1, 1);
    send_request(FN_SEND_BYTE, 2'd0, 1'b0, 9'h0, 8'h55);
    read_message(2'd3, 1'b1, 1);
    send_message(2'd2, 1'b0, 3);
    read_message(2'd2, 1'b0, 1);
    read_message(2'd2, 1'b0, 3);
    send_message(2'd1, 1'b1, 2);
    send_message(2'd1, 1'b1, 1);
  endtask

  task automatic test_full_ring;
    for (int i = 0; i < 3; i++) send_message(2'd1, 1'b0, 0);
    send_message(2'd1, 1'b0, 256);
    for (int i = 0; i < 188; i++) send_message(2'd1, 1'b0, 0);
    for (int i = 0; i < 3; i++) read_message(2'd1, 1'b0, 0);
    for (int i = 0; i < 4; i++) send_message(2'd1, 1'b0, 0);
    read_message(2'd1, 1'b0, 2);
  endtask

  task automatic test_random_traffic;
    int len;
    while (n_resp + expected_resps.size() < 520) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_message(2'($urandom), 1'($urandom), len);
        4, 5, 6, 7: read_message(2'($urandom), 1'($urandom), len);
        8: send_request(FN_SEND_START, 2'($urandom), 1'($urandom), 9'($urandom),
                        8'($urandom));
        default: send_request(func_t'($urandom_range(0, 3)), 2'($urandom), 1'($urandom),
                              9'($urandom), 8'($urandom));
      endcase
    end
  endtask

  initial begin
    for (int q = 0; q < NQ; q++) begin
      head_ptr[q] = '0;
      tail_ptr[q] = '0;
      msg_cnt[q] = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_cases();
    test_edge_lengths();
    test_full_ring();
    test_random_traffic();
    quiet = 1'b1;
    for (int i = 0; i < 10; i++) read_message(2'($urandom), 1'($urandom), $urandom_range(0, 4));
    idle_input();
    while (expected_resps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d responses: rejections, empty reads, zero and full-size messages,",
             n_resp);
    $display("ring wrap, aborted transfers and random traffic on all eight queues.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
